>>> rtl/core/pose_quaternion_log_difference_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pose log-difference block
// Shared property wrappers; clk and arst_n are taken from the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef POSE_QUATERNION_LOG_DIFFERENCE_DEFINES_SVH
`define POSE_QUATERNION_LOG_DIFFERENCE_DEFINES_SVH

// same-cycle implication
`define PQLD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PQLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pqld_pkg.sv
// ---------------------------------------------------------------------------
// pqld_pkg
// Types, constants and tables shared by the pose log-difference block.
// ---------------------------------------------------------------------------
`default_nettype none

package pqld_pkg;

	localparam int CORDIC_STEPS = 30;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QMUL,
		ST_FLIP,
		ST_SQ,
		ST_SQRT,
		ST_ATAN,
		ST_DMUL,
		ST_DWAIT,
		ST_DIV,
		ST_OUT
	} pqld_state_t;

	// destination component (0..3 = x y z w) and subtract flag of a product
	typedef struct packed {
		logic [1:0] dst;
		logic       neg;
	} pqld_tag_t;

	typedef struct packed {
		logic               vld;
		logic signed [32:0] a;
		logic signed [32:0] b;
		pqld_tag_t          tag;
	} pqld_mul_req_t;

	typedef struct packed {
		logic               vld;
		logic signed [63:0] p;
		pqld_tag_t          tag;
	} pqld_mul_rsp_t;

	// one term of conj(b) * t: product b[asel] * t[bsel]
	typedef struct packed {
		logic [1:0] asel;
		logic [1:0] bsel;
		pqld_tag_t  tag;
	} pqld_term_t;

	function automatic pqld_term_t pqld_qterm(input logic [3:0] idx);
		pqld_term_t r;
		case (idx)
			4'd0:  r = '{asel: 2'd3, bsel: 2'd3, tag: '{dst: 2'd3, neg: 1'b0}};
			4'd1:  r = '{asel: 2'd0, bsel: 2'd0, tag: '{dst: 2'd3, neg: 1'b0}};
			4'd2:  r = '{asel: 2'd1, bsel: 2'd1, tag: '{dst: 2'd3, neg: 1'b0}};
			4'd3:  r = '{asel: 2'd2, bsel: 2'd2, tag: '{dst: 2'd3, neg: 1'b0}};
			4'd4:  r = '{asel: 2'd3, bsel: 2'd0, tag: '{dst: 2'd0, neg: 1'b0}};
			4'd5:  r = '{asel: 2'd0, bsel: 2'd3, tag: '{dst: 2'd0, neg: 1'b1}};
			4'd6:  r = '{asel: 2'd1, bsel: 2'd2, tag: '{dst: 2'd0, neg: 1'b1}};
			4'd7:  r = '{asel: 2'd2, bsel: 2'd1, tag: '{dst: 2'd0, neg: 1'b0}};
			4'd8:  r = '{asel: 2'd3, bsel: 2'd1, tag: '{dst: 2'd1, neg: 1'b0}};
			4'd9:  r = '{asel: 2'd1, bsel: 2'd3, tag: '{dst: 2'd1, neg: 1'b1}};
			4'd10: r = '{asel: 2'd2, bsel: 2'd0, tag: '{dst: 2'd1, neg: 1'b1}};
			4'd11: r = '{asel: 2'd0, bsel: 2'd2, tag: '{dst: 2'd1, neg: 1'b0}};
			4'd12: r = '{asel: 2'd3, bsel: 2'd2, tag: '{dst: 2'd2, neg: 1'b0}};
			4'd13: r = '{asel: 2'd2, bsel: 2'd3, tag: '{dst: 2'd2, neg: 1'b1}};
			4'd14: r = '{asel: 2'd0, bsel: 2'd1, tag: '{dst: 2'd2, neg: 1'b1}};
			4'd15: r = '{asel: 2'd1, bsel: 2'd0, tag: '{dst: 2'd2, neg: 1'b0}};
			default: r = '0;
		endcase
		return r;
	endfunction

	// truncated atan(2^-i) in Q2.30
	function automatic logic [29:0] pqld_atan(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd843314856;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043836;
			5'd3:  r = 30'd133525158;
			5'd4:  r = 30'd67021686;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775850;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194282;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			5'd24: r = 30'd63;
			5'd25: r = 30'd31;
			5'd26: r = 30'd15;
			5'd27: r = 30'd8;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/pqld_mul.sv
// ---------------------------------------------------------------------------
// pqld_mul
// Shared 33x33 signed multiplier with a registered product and tag.
// ---------------------------------------------------------------------------
`default_nettype none

module pqld_mul (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pqld_pkg::pqld_mul_req_t req,
	output pqld_pkg::pqld_mul_rsp_t     rsp
);
	import pqld_pkg::*;

	logic signed [65:0] prod;
	logic               vld_q;
	logic signed [63:0] p_q;
	pqld_tag_t          tag_q;

	assign prod = req.a * req.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		p_q   <= prod[63:0];
		tag_q <= req.tag;
	end

	assign rsp = '{vld: vld_q, p: p_q, tag: tag_q};

endmodule

`default_nettype wire

>>> rtl/core/pqld_isqrt.sv
// ---------------------------------------------------------------------------
// pqld_isqrt
// Floor integer square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pqld_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] n,
	output logic             done,
	output logic [31:0]      root
);
	import pqld_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= n;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

`default_nettype wire

>>> rtl/core/pqld_cordic.sv
// ---------------------------------------------------------------------------
// pqld_cordic
// Vectoring CORDIC atan2(y, x), one micro-rotation per cycle, Q2.30 angle.
// ---------------------------------------------------------------------------
`default_nettype none

module pqld_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [31:0]        y0,
	input  wire logic signed [32:0] x0,
	output logic                    done,
	output logic [30:0]             half
);
	import pqld_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [4:0]         i_q;
	logic signed [35:0] x_q;
	logic signed [35:0] y_q;
	logic signed [32:0] z_q;
	logic signed [35:0] xs;
	logic signed [35:0] ys;
	logic signed [32:0] ang;

	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign ang = signed'({3'b000, pqld_atan(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= 36'(x0);
			y_q <= signed'({4'b0000, y0});
			z_q <= '0;
		end else if (busy_q) begin
			if (y_q > 36'sd0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end
		end
	end

	// negative angles clamp to zero
	assign done = done_q;
	assign half = z_q[32] ? 31'd0 : z_q[30:0];

endmodule

`default_nettype wire

>>> rtl/core/pqld_div.sv
// ---------------------------------------------------------------------------
// pqld_div
// Restoring divider, 64-bit dividend by 33-bit divisor, 32-bit quotient.
// Quotient must fit 32 bits (dividend high word below divisor).
// ---------------------------------------------------------------------------
`default_nettype none

module pqld_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [32:0] den,
	output logic             done,
	output logic [31:0]      quo
);
	import pqld_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] low_q;
	logic [31:0] quo_q;
	logic [32:0] den_q;
	logic [33:0] trial;
	logic        fits;

	assign trial = {rem_q, low_q[31]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num[63:32]};
			low_q <= num[31:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 33'(trial - {1'b0, den_q}) : trial[32:0];
			low_q <= {low_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/pose_quaternion_log_difference.sv
// ---------------------------------------------------------------------------
// pose_quaternion_log_difference
// Tangent-space difference between a target pose and a stored base pose.
// ---------------------------------------------------------------------------
// A beat with tuser = 0 stores its pose as the base and gives no result. A
// beat with tuser = 1 gives one result beat: the saturated position
// difference and the rotation vector of conj(base) * target. A target beat
// is worked by one shared 33x33 multiplier (16 quaternion products, 3
// squares, 3 scaling products), a bit-serial square root (32 iterations), a
// 30-step CORDIC atan2 and a bit-serial divider (32 iterations per element,
// after its scaling product). When the relative rotation has a zero vector
// part, the CORDIC and divider phases are skipped. s_axis_tready is high
// only while the sequencer is idle; a finished result waits in the output
// register, and the next input beat may be taken meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pose_quaternion_log_difference_defines.svh"

module pose_quaternion_log_difference (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w (32 bits each, from bit 0)
	input  wire logic [223:0]  s_axis_tdata,
	// req_type
	input  wire logic [0:0]    s_axis_tuser,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// delta_pos_x, delta_pos_y, delta_pos_z, delta_rot_x, delta_rot_y, delta_rot_z
	output logic [191:0]       m_axis_tdata
);
	import pqld_pkg::*;

	localparam logic signed [35:0] DQ_HI = 36'sd2147483648;
	localparam logic signed [35:0] DQ_LO = -36'sd2147483648;
	localparam logic signed [63:0] RND   = 64'sd536870912;

	pqld_state_t state_q, state_d;

	logic [4:0]         cnt_q;
	logic [1:0]         idx_q;
	logic signed [31:0] base_pos_q [3];
	logic signed [31:0] base_rot_q [4];
	logic signed [31:0] tgt_q      [4];
	logic [31:0]        dpos_q     [3];
	logic signed [35:0] acc_q      [4];
	logic signed [32:0] dq_q       [4];
	logic [63:0]        sq_q;
	logic [31:0]        s_q;
	logic [30:0]        half_q;
	logic [31:0]        rot_q      [3];
	logic [191:0]       out_q;
	logic               out_vld_q;

	logic               accept;
	pqld_term_t         term;
	pqld_mul_req_t      mreq;
	pqld_mul_rsp_t      mrsp;
	logic signed [63:0] rnd_full;
	logic signed [35:0] rnd;
	logic signed [32:0] dq_sel;
	logic [31:0]        mag;
	logic               out_free;

	logic        sqrt_start, sqrt_done;
	logic [31:0] sqrt_root;
	logic        atan_start, atan_done;
	logic [30:0] atan_half;
	logic        div_start, div_done;
	logic [31:0] div_quo;
	logic [63:0] div_num;
	logic [32:0] rot_signed;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;
	assign term     = pqld_qterm(cnt_q[3:0]);
	assign dq_sel   = dq_q[idx_q];
	assign mag      = dq_sel[32] ? 32'(-dq_sel) : dq_sel[31:0];
	assign rnd_full = (mrsp.p + RND) >>> 30;
	assign rnd      = rnd_full[35:0];
	assign div_num  = mrsp.p + {32'd0, s_q};
	assign rot_signed = dq_sel[32] ? 33'(-{1'b0, div_quo}) : {1'b0, div_quo};

	// sequencer: next state and unit controls
	always_comb begin
		state_d    = state_q;
		mreq       = '0;
		sqrt_start = 1'b0;
		atan_start = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && s_axis_tuser[0]) state_d = ST_QMUL;
			end
			ST_QMUL: begin
				if (!cnt_q[4]) begin
					mreq.vld = 1'b1;
					mreq.a   = 33'(base_rot_q[term.asel]);
					mreq.b   = 33'(tgt_q[term.bsel]);
					mreq.tag = term.tag;
				end else begin
					state_d = ST_FLIP;
				end
			end
			ST_FLIP: state_d = ST_SQ;
			ST_SQ: begin
				if (cnt_q < 5'd3) begin
					mreq.vld = 1'b1;
					mreq.a   = dq_q[cnt_q[1:0]];
					mreq.b   = dq_q[cnt_q[1:0]];
				end else begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				sqrt_start = (cnt_q == 5'd0);
				if (sqrt_done) state_d = (sqrt_root == 32'd0) ? ST_OUT : ST_ATAN;
			end
			ST_ATAN: begin
				atan_start = (cnt_q == 5'd0);
				if (atan_done) state_d = ST_DMUL;
			end
			ST_DMUL: begin
				mreq.vld = 1'b1;
				mreq.a   = {2'b00, half_q};
				mreq.b   = {1'b0, mag};
				state_d  = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (mrsp.vld) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) state_d = (idx_q == 2'd2) ? ST_OUT : ST_DMUL;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// counters, base pose and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < 3; i++) base_pos_q[i] <= '0;
			for (int i = 0; i < 3; i++) base_rot_q[i] <= '0;
			base_rot_q[3] <= 32'sh4000_0000;
		end else begin
			if (state_d != state_q) cnt_q <= '0;
			else if (cnt_q != 5'h1f) cnt_q <= cnt_q + 5'd1;

			if (state_q == ST_FLIP) idx_q <= '0;
			else if (state_q == ST_DIV && div_done) idx_q <= idx_q + 2'd1;

			if (accept && !s_axis_tuser[0]) begin
				for (int i = 0; i < 3; i++) base_pos_q[i] <= s_axis_tdata[32*i +: 32];
				for (int i = 0; i < 4; i++) base_rot_q[i] <= s_axis_tdata[96 + 32*i +: 32];
			end

			if (state_q == ST_OUT && out_free) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					for (int i = 0; i < 3; i++) begin
						logic signed [32:0] diff;
						diff = 33'(signed'(s_axis_tdata[32*i +: 32])) - 33'(base_pos_q[i]);
						if (diff[32] != diff[31])
							dpos_q[i] <= diff[32] ? 32'h8000_0000 : 32'h7fff_ffff;
						else
							dpos_q[i] <= diff[31:0];
					end
					for (int i = 0; i < 4; i++) tgt_q[i] <= s_axis_tdata[96 + 32*i +: 32];
					for (int i = 0; i < 4; i++) acc_q[i] <= '0;
					for (int i = 0; i < 3; i++) rot_q[i] <= '0;
				end
			end
			ST_QMUL: begin
				if (mrsp.vld)
					acc_q[mrsp.tag.dst] <= mrsp.tag.neg ? acc_q[mrsp.tag.dst] - rnd
						: acc_q[mrsp.tag.dst] + rnd;
			end
			ST_FLIP: begin
				for (int i = 0; i < 4; i++) begin
					logic signed [35:0] v;
					v = acc_q[3][35] ? -acc_q[i] : acc_q[i];
					if (v > DQ_HI) dq_q[i] <= DQ_HI[32:0];
					else if (v < DQ_LO) dq_q[i] <= DQ_LO[32:0];
					else dq_q[i] <= v[32:0];
				end
				sq_q <= '0;
			end
			ST_SQ: begin
				if (mrsp.vld) sq_q <= sq_q + mrsp.p;
			end
			ST_SQRT: begin
				if (sqrt_done) s_q <= sqrt_root;
			end
			ST_ATAN: begin
				if (atan_done) half_q <= atan_half;
			end
			ST_DIV: begin
				if (div_done) rot_q[idx_q] <= rot_signed[31:0];
			end
			ST_OUT: begin
				if (out_free)
					out_q <= {rot_q[2], rot_q[1], rot_q[0], dpos_q[2], dpos_q[1], dpos_q[0]};
			end
			default: ;
		endcase
	end

	pqld_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	pqld_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.n      (sq_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	pqld_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (atan_start),
		.y0     (s_q),
		.x0     (dq_q[3]),
		.done   (atan_done),
		.half   (atan_half)
	);

	pqld_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    ({s_q, 1'b0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	`PQLD_ASSERT_NEXT(a_base_no_work, accept && !s_axis_tuser[0], state_q == ST_IDLE,
		"base beat started work")
	`PQLD_ASSERT_NEXT(a_target_starts, accept && s_axis_tuser[0], state_q == ST_QMUL,
		"target beat did not start products")
	`PQLD_ASSERT_NOW(a_flip_sign, state_q == ST_SQ, !dq_q[3][32],
		"scalar part negative after sign flip")
	`PQLD_ASSERT_NOW(a_mul_owner, mrsp.vld,
		state_q == ST_QMUL || state_q == ST_SQ || state_q == ST_DWAIT,
		"product returned outside a multiply phase")

endmodule

`default_nettype wire
